### design/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

`endif

### design/htr_pkg.sv
// Shared types, constants and the tap fraction table for the reverb block.
`default_nettype none

package htr_pkg;

    localparam int MIX_WIDTH      = 4;
    localparam int ROM_SIZE       = 64;
    localparam int ROM_AW         = 6;
    localparam int FRAC_BITS      = 16;
    localparam int SEG_BITS       = 15;
    localparam int GAIN_BITS      = 16;
    localparam int GAIN_COUNT     = 4;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SEGMENT_LENGTH = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_STAGE0    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_STAGE1    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_STAGE2    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_STAGE3    = 3'd4;

    typedef logic [FRAC_BITS-1:0] frac_rom_t [ROM_SIZE];

    // Additive lagged-Fibonacci generator, seeded by a multiplicative fill.
    function automatic frac_rom_t build_frac_rom();
        logic [31:0] ring [34];
        frac_rom_t   rom;
        logic [63:0] t;
        logic [31:0] v;
        int          i;
        int          k;
        rom = '{default: '0};
        k = 0;
        ring[0] = 32'd1053;
        for (i = 1; i < 31; i++)
        begin
            t = {32'd0, ring[i-1]} * 64'd16807;
            t = t % 64'd2147483647;
            ring[i] = t[31:0];
        end
        for (i = 31; i < 34; i++)
        begin
            ring[i] = ring[i-31];
        end
        i = 34;
        while (k < ROM_SIZE)
        begin
            v = ring[(i - 31) % 34] + ring[(i - 3) % 34];
            ring[i % 34] = v;
            if (i >= 344)
            begin
                rom[k] = v[31:16];
                k++;
            end
            i++;
        end
        return rom;
    endfunction

    localparam frac_rom_t FRAC_ROM = build_frac_rom();

    typedef struct packed {
        logic clear;
        logic off_issue;
        logic wrap_step;
        logic start;
        logic rd_issue;
        logic wr_issue;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

### design/householder_tap_reverb.sv
// A sample pair is taken only while idle. The block reads every tap, then writes
// the taps back, and takes no new pair until the result has gone to the output
// register; one tank memory port serves the 32 tap reads and 32 write-backs of each sample.
// Reset clears the tank in a pass over every word, then builds the tap offsets and
// reduces the write position; a segment length write repeats that step.
// Configuration writes are taken at any time and need no handshake.
`default_nettype none

module householder_tap_reverb
    import htr_pkg::*;
#(
    parameter int TANK_DEPTH  = 524288,
    parameter int GUARD_SPAN  = 32,
    parameter int STAGE_COUNT = 4,
    parameter int SAMPLE_BITS = 24
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // Fields from bit 0: left_in, right_in.
    input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // Fields from bit 0: left_out, right_out.
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]         m_axis_tdata,
    input  wire logic                                  cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0]             cfg_addr,
    input  wire logic [CFG_DATA_BITS-1:0]              cfg_wdata
);

    localparam int DATA_BITS = ((2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int AW        = $clog2(TANK_DEPTH);

    dp_cmd_t                cmd;
    dp_status_t             status;
    logic [AW-1:0]          cnt;
    logic [SAMPLE_BITS-1:0] out_left, out_right;

    htr_ctrl #(
        .TANK_DEPTH  (TANK_DEPTH),
        .STAGE_COUNT (STAGE_COUNT)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_valid  (s_axis_tvalid),
        .s_ready  (s_axis_tready),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .status   (status),
        .cmd      (cmd),
        .cnt      (cnt)
    );

    htr_datapath #(
        .TANK_DEPTH  (TANK_DEPTH),
        .GUARD_SPAN  (GUARD_SPAN),
        .STAGE_COUNT (STAGE_COUNT),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .cnt       (cnt),
        .in_left   (s_axis_tdata[SAMPLE_BITS-1:0]),
        .in_right  (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .out_left  (out_left),
        .out_right (out_right),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status)
    );

    assign m_axis_tdata = DATA_BITS'({out_right, out_left});

endmodule

`default_nettype wire

### design/htr_ctrl.sv
// Sequencing state machine for the reverb block.
`default_nettype none

module htr_ctrl
    import htr_pkg::*;
#(
    parameter int TANK_DEPTH  = 524288,
    parameter int STAGE_COUNT = 4
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_addr,
    input  wire dp_status_t                status,
    output dp_cmd_t                        cmd,
    output logic [$clog2(TANK_DEPTH)-1:0]  cnt
);

    localparam int AW  = $clog2(TANK_DEPTH);
    localparam int TAP = 2 * STAGE_COUNT * MIX_WIDTH;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_OFFS  = 8'b0000_0100,
        S_WRAP  = 8'b0000_1000,
        S_READ  = 8'b0001_0000,
        S_DRAIN = 8'b0010_0000,
        S_WRITE = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t          state_reg, state_next;
    logic [AW-1:0]   cnt_reg, cnt_next;
    logic            req_reg, req_next;
    logic            seg_write;

    assign seg_write = cfg_we && (cfg_addr == REG_SEGMENT_LENGTH);
    assign cnt = cnt_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg + 1'b1;
        req_next   = req_reg | seg_write;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (cnt_reg == AW'(TANK_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                    cnt_next   = '0;
                end
            end
            S_IDLE:
            begin
                cnt_next = '0;
                s_ready  = !req_reg;
                if (req_reg)
                begin
                    state_next = S_OFFS;
                    req_next   = seg_write;
                end
                else if (s_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_READ;
                end
            end
            S_OFFS:
            begin
                cmd.off_issue = (cnt_reg < AW'(TAP));
                if (cnt_reg == AW'(TAP + 1))
                begin
                    state_next = S_WRAP;
                    cnt_next   = '0;
                end
            end
            S_WRAP:
            begin
                cmd.wrap_step = 1'b1;
                if (cnt_reg == AW'(AW - 1))
                begin
                    state_next = S_IDLE;
                    cnt_next   = '0;
                end
            end
            S_READ:
            begin
                cmd.rd_issue = 1'b1;
                if (cnt_reg == AW'(TAP - 1))
                begin
                    state_next = S_DRAIN;
                    cnt_next   = '0;
                end
            end
            S_DRAIN:
            begin
                if (cnt_reg == AW'(1))
                begin
                    state_next = S_WRITE;
                    cnt_next   = '0;
                end
            end
            S_WRITE:
            begin
                cmd.wr_issue = 1'b1;
                if (cnt_reg == AW'(TAP - 1))
                begin
                    state_next = S_DONE;
                    cnt_next   = '0;
                end
            end
            S_DONE:
            begin
                cnt_next = '0;
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
                cnt_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cnt_reg   <= '0;
            req_reg   <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            req_reg   <= req_next;
        end
    end

endmodule

`default_nettype wire

### design/htr_datapath.sv
// Tank memory, tap offsets, mixing arithmetic and output register.
`default_nettype none

module htr_datapath
    import htr_pkg::*;
#(
    parameter int TANK_DEPTH  = 524288,
    parameter int GUARD_SPAN  = 32,
    parameter int STAGE_COUNT = 4,
    parameter int SAMPLE_BITS = 24
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0]     cfg_addr,
    input  wire logic [CFG_DATA_BITS-1:0]      cfg_wdata,
    input  wire dp_cmd_t                       cmd,
    input  wire logic [$clog2(TANK_DEPTH)-1:0] cnt,
    input  wire logic [SAMPLE_BITS-1:0]        in_left,
    input  wire logic [SAMPLE_BITS-1:0]        in_right,
    output logic [SAMPLE_BITS-1:0]             out_left,
    output logic [SAMPLE_BITS-1:0]             out_right,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output dp_status_t                         status
);

    localparam int AW       = $clog2(TANK_DEPTH);
    localparam int LW       = $clog2(TANK_DEPTH + 1);
    localparam int EW       = (LW > SEG_BITS) ? LW : SEG_BITS;
    localparam int TAP      = 2 * STAGE_COUNT * MIX_WIDTH;
    localparam int TW       = $clog2(TAP);
    localparam int GIW      = TW - 2;
    localparam int GROUPS   = 2 * STAGE_COUNT;
    localparam int HALF_IDX = STAGE_COUNT * MIX_WIDTH;
    localparam int SEG_MAX  = TANK_DEPTH / TAP;
    localparam int SB       = SAMPLE_BITS;
    localparam int PW       = SB + GAIN_BITS + 1;
    localparam int ACW      = PW + 4;
    localparam int XW       = LW + AW;
    localparam int OPW      = FRAC_BITS + EW;

    function automatic logic signed [SB-1:0] sat_sb(input logic signed [ACW-1:0] x);
        logic signed [ACW-1:0] hi;
        logic signed [ACW-1:0] lo;
        hi = {{(ACW - SB + 1){1'b0}}, {(SB - 1){1'b1}}};
        lo = ~hi;
        if (x > hi)
            return hi[SB-1:0];
        else if (x < lo)
            return lo[SB-1:0];
        else
            return x[SB-1:0];
    endfunction

    logic [SEG_BITS-1:0]  seg_reg;
    logic [GAIN_BITS-1:0] gain_reg [GAIN_COUNT];
    logic [EW-1:0]        seg_eff;
    logic [LW-1:0]        len;
    logic [LW-1:0]        half;

    always_comb
    begin
        if (EW'(seg_reg) < EW'(GUARD_SPAN))
            seg_eff = EW'(GUARD_SPAN);
        else if (EW'(seg_reg) > EW'(SEG_MAX))
            seg_eff = EW'(SEG_MAX);
        else
            seg_eff = EW'(seg_reg);
    end

    assign len  = LW'(seg_eff * EW'(TAP));
    assign half = len >> 1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg  <= SEG_BITS'(3868);
            gain_reg <= '{default: '0};
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_SEGMENT_LENGTH: seg_reg     <= cfg_wdata[SEG_BITS-1:0];
                REG_GAIN_STAGE0:    gain_reg[0] <= cfg_wdata[GAIN_BITS-1:0];
                REG_GAIN_STAGE1:    gain_reg[1] <= cfg_wdata[GAIN_BITS-1:0];
                REG_GAIN_STAGE2:    gain_reg[2] <= cfg_wdata[GAIN_BITS-1:0];
                REG_GAIN_STAGE3:    gain_reg[3] <= cfg_wdata[GAIN_BITS-1:0];
                default:            ;
            endcase
        end
    end

    // Offset table: fraction product first, then base plus scaled fraction, plus half the length on dup taps.
    logic [TW-1:0]  k;
    logic [TW-1:0]  kk;
    logic           dup;
    logic [OPW-1:0] oprod_reg;
    logic [TW-1:0]  okk_reg, ok_reg;
    logic           odup_reg, ovld_reg;
    logic [AW-1:0]  off_reg [TAP];

    assign k   = cnt[TW-1:0];
    assign dup = (k >= TW'(HALF_IDX)) && ((k[1:0] == 2'd0) || (k[1:0] == 2'd3));
    assign kk  = dup ? (k - TW'(HALF_IDX)) : k;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovld_reg <= 1'b0;
        else
            ovld_reg <= cmd.off_issue;
    end

    always_ff @(posedge clk)
    begin
        oprod_reg <= OPW'(FRAC_ROM[ROM_AW'(kk)]) * OPW'(seg_eff - EW'(GUARD_SPAN));
        okk_reg   <= kk;
        ok_reg    <= k;
        odup_reg  <= dup;
        if (ovld_reg)
        begin
            off_reg[ok_reg] <= AW'(XW'(okk_reg) * XW'(seg_eff) + XW'(oprod_reg >> FRAC_BITS)
                                   + (odup_reg ? XW'(half) : XW'(0)));
        end
    end

    // Write position: advances and wraps with each result, with a shift-subtract reduction after a length change.
    logic [AW-1:0] wp_reg;
    logic [AW-1:0] sh;
    logic [XW-1:0] lsh;

    assign sh  = AW'(AW - 1) - cnt;
    assign lsh = XW'(len) << sh;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wp_reg <= '0;
        else if (cmd.wrap_step)
        begin
            if (XW'(wp_reg) >= lsh)
                wp_reg <= wp_reg - lsh[AW-1:0];
        end
        else if (cmd.finish)
        begin
            if (LW'(wp_reg) + LW'(1) >= len)
                wp_reg <= '0;
            else
                wp_reg <= wp_reg + 1'b1;
        end
    end

    // Tap address and tank memory.
    logic [AW:0]    diff;
    logic [AW-1:0]  tap_addr;
    logic [SB-1:0]  tank [TANK_DEPTH];
    logic [SB-1:0]  rdata_reg;
    logic           we;
    logic [AW-1:0]  waddr;
    logic [SB-1:0]  wdata;

    assign diff     = {1'b0, wp_reg} - {1'b0, off_reg[k]};
    assign tap_addr = diff[AW] ? AW'(diff + (AW+1)'(len)) : diff[AW-1:0];
    assign we       = cmd.clear || cmd.wr_issue;
    assign waddr    = cmd.clear ? cnt : tap_addr;

    always_ff @(posedge clk)
    begin
        if (we)
            tank[waddr] <= wdata;
        rdata_reg <= tank[tap_addr];
    end

    // Read pipeline: group sums, reflection terms and output products.
    logic                    rvld_reg, pvld_reg;
    logic [TW-1:0]           rk_reg;
    logic signed [SB+1:0]    gsum_reg;
    logic signed [SB+1:0]    gnew;
    logic signed [SB:0]      t_reg [GROUPS];
    logic [SB-1:0]           v_reg [TAP];
    logic [GIW-1:0]          rg;
    logic [GIW-1:0]          stage;
    logic [GAIN_BITS-1:0]    gain_sel;
    logic signed [PW-1:0]    prod_reg;
    logic                    pchan_reg;
    logic signed [ACW-1:0]   acc_reg [2];
    logic signed [SB-1:0]    in_left_reg, in_right_reg;

    assign rg    = rk_reg[TW-1:2];
    assign stage = (rg < GIW'(STAGE_COUNT)) ? rg : (rg - GIW'(STAGE_COUNT));
    assign gnew  = ((rk_reg[1:0] == 2'd0) ? (SB+2)'(0) : gsum_reg)
                   + (SB+2)'($signed(rdata_reg));

    always_comb
    begin
        gain_sel = '0;
        for (int i = 0; i < GAIN_COUNT; i++)
        begin
            if ((i < STAGE_COUNT) && (int'(stage) == i) && (rk_reg[1:0] == 2'd0))
                gain_sel = gain_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rvld_reg <= 1'b0;
            pvld_reg <= 1'b0;
        end
        else
        begin
            rvld_reg <= cmd.rd_issue;
            pvld_reg <= rvld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rk_reg <= k;
        if (cmd.start)
        begin
            in_left_reg  <= $signed(in_left);
            in_right_reg <= $signed(in_right);
        end
        if (rvld_reg)
        begin
            v_reg[rk_reg] <= rdata_reg;
            gsum_reg      <= gnew;
            if (rk_reg[1:0] == 2'd3)
                t_reg[rg] <= (SB+1)'(gnew >>> 1);
        end
        prod_reg  <= $signed(rdata_reg) * $signed({1'b0, gain_sel});
        pchan_reg <= (rg >= GIW'(STAGE_COUNT));
        if (cmd.start)
        begin
            acc_reg[0] <= '0;
            acc_reg[1] <= '0;
        end
        else if (pvld_reg)
        begin
            acc_reg[pchan_reg] <= acc_reg[pchan_reg] + ACW'(prod_reg);
        end
    end

    always_comb
    begin
        if (cmd.clear)
            wdata = '0;
        else if (k == TW'(0))
            wdata = in_left_reg;
        else if (k == TW'(HALF_IDX))
            wdata = in_right_reg;
        else
            wdata = sat_sb(ACW'($signed(v_reg[k])) - ACW'(t_reg[k[TW-1:2]]));
    end

    // Output register.
    logic                 out_valid_reg;
    logic signed [SB-1:0] out_left_reg, out_right_reg;

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_left        = out_left_reg;
    assign out_right       = out_right_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_left_reg  <= sat_sb(acc_reg[1] >>> GAIN_BITS);
            out_right_reg <= sat_sb(acc_reg[0] >>> GAIN_BITS);
        end
    end

endmodule

`default_nettype wire

### design/htr_checker.sv
// Port-level checks for the reverb block and their binding.
`default_nettype none
`include "assert_macros.svh"

module htr_checker
    import htr_pkg::*;
#(
    parameter int DATA_BITS = 48
)
(
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      s_axis_tvalid,
    input wire logic                      s_axis_tready,
    input wire logic                      m_axis_tvalid,
    input wire logic                      m_axis_tready,
    input wire logic [DATA_BITS-1:0]      m_axis_tdata,
    input wire logic                      cfg_we,
    input wire logic [CFG_INDEX_BITS-1:0] cfg_addr
);

    logic in_xfer;

    assign in_xfer = s_axis_tvalid && s_axis_tready;

    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_xfer, !s_axis_tready)
    `ASSERT_NEXT(a_seg_rebuild, clk, rst_n, cfg_we && (cfg_addr == REG_SEGMENT_LENGTH), !s_axis_tready)
    `ASSERT_NEXT(a_no_early_result, clk, rst_n, in_xfer, !m_axis_tvalid || $stable(m_axis_tdata))

endmodule

bind householder_tap_reverb htr_checker #(.DATA_BITS(DATA_BITS)) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr)
);

`default_nettype wire
